// ----- hw/rtl/bhd_pkg.sv -----
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared widths, codes and reset values for the button hold decoder.
// ----------------------------------------------------------------------------
package bhd_pkg;

  localparam int TIME_W = 32;
  localparam int HELD_W = 23;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MS_PER_SECOND_DEF = 1000;

  typedef enum logic [1:0] {
    BUZZ_NONE = 2'd0,
    BUZZ_ON   = 2'd1,
    BUZZ_OFF  = 2'd2
  } buzz_cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_ESTOP    = 3'd1,
    ACT_DOCK     = 3'd2,
    ACT_MOW      = 3'd3,
    ACT_SHUTDOWN = 3'd4
  } action_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_LEN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOCK     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOW      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHUTDOWN = 3'd4;

  localparam logic [15:0] BEEP_LEN_RST = 16'd100;
  localparam logic [7:0]  STOP_RST     = 8'd1;
  localparam logic [7:0]  DOCK_RST     = 8'd5;
  localparam logic [7:0]  MOW_RST      = 8'd6;
  localparam logic [7:0]  SHUTDOWN_RST = 8'd9;

endpackage

// ----- hw/rtl/bhd_held_calc.sv -----
// ----------------------------------------------------------------------------
// bhd_held_calc
// Elapsed milliseconds to whole seconds, saturated to the held_seconds width.
// ----------------------------------------------------------------------------
module bhd_held_calc #(
  parameter int MS_PER_SECOND = bhd_pkg::MS_PER_SECOND_DEF
) (
  input  logic [bhd_pkg::TIME_W-1:0] elapsed_ms,
  output logic [bhd_pkg::HELD_W-1:0] held_s
);
  import bhd_pkg::*;

  // exact floor division for 32-bit dividends: 33-bit reciprocal, shift 32+L
  localparam int SHIFT = TIME_W + $clog2(MS_PER_SECOND);
  localparam logic [2*TIME_W:0] ONE_W = (2*TIME_W+1)'(1);
  localparam logic [2*TIME_W:0] DIV_W = (2*TIME_W+1)'(MS_PER_SECOND);
  localparam logic [TIME_W:0] RECIP =
    (TIME_W+1)'(((ONE_W << SHIFT) + DIV_W - ONE_W) / DIV_W);

  logic [2*TIME_W:0] product;
  logic [TIME_W-1:0] quot;

  assign product = (2*TIME_W+1)'(elapsed_ms) * (2*TIME_W+1)'(RECIP);
  assign quot    = TIME_W'(product >> SHIFT);

  always_comb begin
    if (|quot[TIME_W-1:HELD_W]) begin
      held_s = '1;
    end else begin
      held_s = quot[HELD_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/button_hold_decoder_core.sv -----
// ----------------------------------------------------------------------------
// button_hold_decoder_core
// Registers: input register, then result register.
// Throughput: one tick per cycle while out_stall is low; the state update and the ms-to-seconds
//   multiply fit in the single compute stage.
// Reset (rst, synchronous): pipeline empty, no beep pending, not holding,
//   thresholds and beep length back to their defaults.
// ----------------------------------------------------------------------------
module button_hold_decoder_core #(
  parameter int MS_PER_SECOND = bhd_pkg::MS_PER_SECOND_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bhd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bhd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bhd_pkg::TIME_W-1:0]      time_ms,
  input  logic                            button_level,
  input  logic                            hold_allowed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      buzzer_cmd,
  output logic [2:0]                      action,
  output logic [bhd_pkg::HELD_W-1:0]      held_seconds
);
  import bhd_pkg::*;

  // configuration
  logic [15:0] beep_length_ms;
  logic [7:0]  stop_hold_s, dock_hold_s, mow_hold_s, shutdown_hold_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      beep_length_ms  <= BEEP_LEN_RST;
      stop_hold_s     <= STOP_RST;
      dock_hold_s     <= DOCK_RST;
      mow_hold_s      <= MOW_RST;
      shutdown_hold_s <= SHUTDOWN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BEEP_LEN: beep_length_ms  <= cfg_data;
        CFG_STOP:     stop_hold_s     <= cfg_data[7:0];
        CFG_DOCK:     dock_hold_s     <= cfg_data[7:0];
        CFG_MOW:      mow_hold_s      <= cfg_data[7:0];
        CFG_SHUTDOWN: shutdown_hold_s <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid;
  logic out_free;
  logic s1_fire;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign s1_fire  = s1_valid && out_free;

  // input register
  logic [TIME_W-1:0] s1_time;
  logic              s1_level;
  logic              s1_allowed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_time    <= time_ms;
      s1_level   <= button_level;
      s1_allowed <= hold_allowed;
    end
  end

  // decoder state
  logic              prev_level, prev_level_next;
  logic              holding, holding_next;
  logic [TIME_W-1:0] hold_start_ms, hold_start_ms_next;
  logic [HELD_W-1:0] last_feedback_s, last_feedback_s_next;
  logic [TIME_W-1:0] beep_deadline_ms, beep_deadline_ms_next;
  logic              beep_pending, beep_pending_next;

  logic [TIME_W-1:0] elapsed_ms;
  logic [TIME_W-1:0] since_deadline;
  logic [HELD_W-1:0] held_calc;
  logic [HELD_W-1:0] held;
  buzz_cmd_t         buzz;
  action_t           act;

  assign elapsed_ms     = holding ? (s1_time - hold_start_ms) : '0;
  assign since_deadline = s1_time - beep_deadline_ms;

  bhd_held_calc #(
    .MS_PER_SECOND(MS_PER_SECOND)
  ) u_held_calc (
    .elapsed_ms(elapsed_ms),
    .held_s    (held_calc)
  );

  always_comb begin
    prev_level_next       = s1_level;
    holding_next          = holding;
    hold_start_ms_next    = hold_start_ms;
    last_feedback_s_next  = last_feedback_s;
    beep_deadline_ms_next = beep_deadline_ms;
    beep_pending_next     = beep_pending;
    buzz                  = BUZZ_NONE;
    act                   = ACT_NONE;
    held                  = '0;

    // deadline reached when the wrapped difference is non-negative
    if (beep_pending && !since_deadline[TIME_W-1]) begin
      buzz              = BUZZ_OFF;
      beep_pending_next = 1'b0;
    end

    if (s1_level && !prev_level && !s1_allowed) begin
      act = ACT_ESTOP;
    end

    if (s1_level) begin
      if (!holding) begin
        hold_start_ms_next   = s1_time;
        last_feedback_s_next = '0;
        holding_next         = 1'b1;
      end
      held = held_calc;
      if (held > last_feedback_s_next) begin
        last_feedback_s_next  = held;
        buzz                  = BUZZ_ON;
        beep_deadline_ms_next = s1_time + TIME_W'(beep_length_ms);
        beep_pending_next     = 1'b1;
      end
    end else if (prev_level && holding) begin
      held = held_calc;
      if (beep_pending_next) begin
        buzz              = BUZZ_OFF;
        beep_pending_next = 1'b0;
      end
      if (held >= HELD_W'(shutdown_hold_s)) begin
        act = ACT_SHUTDOWN;
      end else if (held >= HELD_W'(mow_hold_s)) begin
        act = ACT_MOW;
      end else if (held >= HELD_W'(dock_hold_s)) begin
        act = ACT_DOCK;
      end else if (held >= HELD_W'(stop_hold_s)) begin
        act = ACT_ESTOP;
      end
      hold_start_ms_next   = '0;
      last_feedback_s_next = '0;
      holding_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level       <= 1'b0;
      holding          <= 1'b0;
      hold_start_ms    <= '0;
      last_feedback_s  <= '0;
      beep_deadline_ms <= '0;
      beep_pending     <= 1'b0;
    end else if (s1_fire) begin
      prev_level       <= prev_level_next;
      holding          <= holding_next;
      hold_start_ms    <= hold_start_ms_next;
      last_feedback_s  <= last_feedback_s_next;
      beep_deadline_ms <= beep_deadline_ms_next;
      beep_pending     <= beep_pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      buzzer_cmd   <= buzz;
      action       <= act;
      held_seconds <= held;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for button_hold_decoder_core. A directed script walks
// reset, every action code, beep start/stop and time wrap, then random press
// and release sequences run under several threshold and beep settings, with
// random stalls on both handshakes in all but the last. Each result is checked
// against a local model of the decoder or against a typed script expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bhd_pkg::*;

  localparam logic [31:0] MS_PER_SEC = MS_PER_SECOND_DEF;
  localparam logic [31:0] HELD_MAX = 32'h007F_FFFF;
  localparam int CFG_LAST_INDEX = (1 << CFG_INDEX_W) - 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_STALL_CYCLES = 80;
  localparam int QUIET_LIMIT = 3000;
  localparam int N_SCRIPT = 23;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        level;
    logic        allowed;
  } tick_t;

  typedef struct packed {
    buzz_cmd_t   buzz;
    action_t     act;
    logic [22:0] held;
  } tick_result_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        level;
    logic        allowed;
    bit          typed;
    buzz_cmd_t   buzz;
    action_t     act;
    logic [22:0] held;
  } script_row_t;

  typedef enum {HOOK_NONE, HOOK_LONG_STALL, HOOK_PAUSE} phase_hook_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [TIME_W-1:0]      time_ms = '0;
  logic                   button_level = 1'b0;
  logic                   hold_allowed = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             buzzer_cmd;
  logic [2:0]             action;
  logic [HELD_W-1:0]      held_seconds;

  button_hold_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .time_ms      (time_ms),
    .button_level (button_level),
    .hold_allowed (hold_allowed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .buzzer_cmd   (buzzer_cmd),
    .action       (action),
    .held_seconds (held_seconds)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // decoder model: configuration and state
  logic [15:0] beep_len_cfg = BEEP_LEN_RST;
  logic [7:0]  stop_cfg     = STOP_RST;
  logic [7:0]  dock_cfg     = DOCK_RST;
  logic [7:0]  mow_cfg      = MOW_RST;
  logic [7:0]  shutdown_cfg = SHUTDOWN_RST;

  logic        btn_prev   = 1'b0;
  logic        holding    = 1'b0;
  logic [31:0] hold_start = '0;
  logic [22:0] beeped_s   = '0;
  logic [31:0] beep_due   = '0;
  logic        beep_armed = 1'b0;

  tick_result_t pending_results[$];

  int errors = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int beeps_seen = 0;
  int actions_seen = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_stall_req = 1'b0;
  int long_stall_left = 0;
  int rx_burst_left = 0;

  logic [31:0] now_ms = '0;

  script_row_t script [0:N_SCRIPT-1] = '{
    // after reset: nothing happens
    '{32'd0,          1'b0, 1'b1, 1'b1, BUZZ_NONE, ACT_NONE,     23'd0},
    // press while busy: immediate emergency stop
    '{32'd1000,       1'b1, 1'b0, 1'b1, BUZZ_NONE, ACT_ESTOP,    23'd0},
    '{32'd2000,       1'b1, 1'b0, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd2100,       1'b1, 1'b0, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd3500,       1'b0, 1'b0, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd4000,       1'b0, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    // shutdown hold, released with beep still on
    '{32'd10000,      1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd19000,      1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd19050,      1'b0, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    // mow hold, beep expires on the release tick
    '{32'd20000,      1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd26999,      1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd27200,      1'b0, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    // dock hold with no intermediate tick
    '{32'd30000,      1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd35000,      1'b0, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    // short tap: no action
    '{32'd36000,      1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd36999,      1'b0, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    // beep deadline wraps to exactly zero
    '{32'hFFFF_FB50,  1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'hFFFF_FF9C,  1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd0,          1'b1, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    '{32'd2000,       1'b0, 1'b1, 1'b0, BUZZ_NONE, ACT_NONE,     23'd0},
    // time steps backwards: held seconds reach 4294967, the most that 32-bit ms allow
    '{32'd100,        1'b1, 1'b0, 1'b1, BUZZ_NONE, ACT_ESTOP,    23'd0},
    '{32'd50,         1'b1, 1'b0, 1'b1, BUZZ_ON,   ACT_NONE,     23'd4294967},
    '{32'hFFFF_FFFF,  1'b0, 1'b1, 1'b1, BUZZ_OFF,  ACT_SHUTDOWN, 23'd4294967}
  };

  function automatic logic [22:0] seconds_held(input logic [31:0] stamp);
    logic [31:0] secs;
    secs = (stamp - hold_start) / MS_PER_SEC;
    return (secs > HELD_MAX) ? HELD_MAX[22:0] : secs[22:0];
  endfunction

  function automatic tick_result_t predict_tick(input tick_t t);
    tick_result_t r;
    logic [31:0]  past_due;
    r.buzz = BUZZ_NONE;
    r.act = ACT_NONE;
    r.held = '0;
    past_due = t.time_ms - beep_due;
    if (beep_armed && past_due < 32'h8000_0000) begin
      r.buzz = BUZZ_OFF;
      beep_armed = 1'b0;
      beep_due = '0;
    end
    if (t.level && !btn_prev && !t.allowed) r.act = ACT_ESTOP;
    if (t.level) begin
      if (!holding) begin
        hold_start = t.time_ms;
        beeped_s = '0;
        holding = 1'b1;
      end
      r.held = seconds_held(t.time_ms);
      if (r.held > beeped_s) begin
        beeped_s = r.held;
        r.buzz = BUZZ_ON;
        beep_due = t.time_ms + beep_len_cfg;
        beep_armed = 1'b1;
      end
    end else if (btn_prev && holding) begin
      r.held = seconds_held(t.time_ms);
      if (beep_armed) begin
        r.buzz = BUZZ_OFF;
        beep_armed = 1'b0;
        beep_due = '0;
      end
      // first match wins: shutdown, mow, dock, stop
      if (r.held >= shutdown_cfg) r.act = ACT_SHUTDOWN;
      else if (r.held >= mow_cfg) r.act = ACT_MOW;
      else if (r.held >= dock_cfg) r.act = ACT_DOCK;
      else if (r.held >= stop_cfg) r.act = ACT_ESTOP;
      hold_start = '0;
      beeped_s = '0;
      holding = 1'b0;
    end
    btn_prev = t.level;
    return r;
  endfunction

  function automatic tick_t mk_tick(input logic [31:0] t, input logic lvl, input logic alw);
    tick_t item;
    item.time_ms = t;
    item.level = lvl;
    item.allowed = alw;
    return item;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_tick(input tick_t item, input bit typed, input tick_result_t typed_res);
    tick_result_t want;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    time_ms <= item.time_ms;
    button_level <= item.level;
    hold_allowed <= item.allowed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_tick(item);
    pending_results.push_back(typed ? typed_res : want);
    ticks_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_BEEP_LEN: beep_len_cfg = data;
      CFG_STOP:     stop_cfg = data[7:0];
      CFG_DOCK:     dock_cfg = data[7:0];
      CFG_MOW:      mow_cfg = data[7:0];
      CFG_SHUTDOWN: shutdown_cfg = data[7:0];
      default: ;
    endcase
  endtask

  // thresholds get junk in the upper byte; only the low byte counts
  task automatic set_config(input logic [15:0] beep, input logic [7:0] stop_s,
                            input logic [7:0] dock_s, input logic [7:0] mow_s,
                            input logic [7:0] shut_s);
    wait_results();
    write_reg(CFG_BEEP_LEN, beep);
    write_reg(CFG_STOP, {8'($urandom), stop_s});
    write_reg(CFG_DOCK, {8'($urandom), dock_s});
    write_reg(CFG_MOW, {8'($urandom), mow_s});
    write_reg(CFG_SHUTDOWN, {8'($urandom), shut_s});
    write_reg(CFG_INDEX_W'($urandom_range(CFG_SHUTDOWN + 1, CFG_LAST_INDEX)),
              16'($urandom));
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic run_random(input int n_ticks, input int long_ms, input phase_hook_t hook);
    int  sent;
    int  step;
    int  hold_len;
    bit  hook_done;
    logic alw;
    sent = 0;
    hook_done = 1'b0;
    while (sent < n_ticks) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          // press, hold for a while, release
          if ($urandom_range(0, 19) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
          case ($urandom_range(0, 2))
            0: step = 150;
            1: step = 1200;
            default: step = long_ms;
          endcase
          hold_len = $urandom_range(1, 16);
          alw = ($urandom_range(0, 3) != 0);
          repeat (hold_len) begin
            now_ms += $urandom_range(0, step);
            send_tick(mk_tick(now_ms, 1'b1, alw), 1'b0, '0);
            sent++;
          end
          now_ms += $urandom_range(0, step);
          send_tick(mk_tick(now_ms, 1'b0, 1'($urandom_range(0, 1))), 1'b0, '0);
          sent++;
        end
        7, 8: begin
          repeat ($urandom_range(1, 3)) begin
            now_ms += $urandom_range(0, 300);
            send_tick(mk_tick(now_ms, 1'b0, 1'($urandom_range(0, 1))), 1'b0, '0);
            sent++;
          end
        end
        default: begin
          // noise: arbitrary times and levels
          repeat ($urandom_range(1, 4)) begin
            send_tick(mk_tick($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                      1'b0, '0);
            sent++;
          end
        end
      endcase
      if (!hook_done && sent >= n_ticks / 2) begin
        hook_done = 1'b1;
        case (hook)
          HOOK_LONG_STALL: long_stall_req = 1'b1;
          HOOK_PAUSE:      wait_results();
          default: ;
        endcase
      end
    end
  endtask

  // result checker and output stall generator
  always @(posedge clk) begin : result_monitor
    tick_result_t want;
    logic stall_next;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (buzzer_cmd !== want.buzz)
          flag_error($sformatf("result %0d buzzer_cmd: got %0d, want %0d",
                               results_seen, buzzer_cmd, want.buzz));
        if (action !== want.act)
          flag_error($sformatf("result %0d action: got %0d, want %0d",
                               results_seen, action, want.act));
        if (held_seconds !== want.held)
          flag_error($sformatf("result %0d held_seconds: got %0d, want %0d",
                               results_seen, held_seconds, want.held));
        if (want.buzz == BUZZ_ON) beeps_seen++;
        if (want.act != ACT_NONE) actions_seen++;
      end
    end
    if (long_stall_req) begin
      long_stall_req = 1'b0;
      long_stall_left = LONG_STALL_CYCLES;
    end
    if (long_stall_left > 0) begin
      long_stall_left--;
      stall_next = 1'b1;
    end else if (rx_burst_left > 0) begin
      rx_burst_left--;
      stall_next = 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_burst_left = $urandom_range(1, 6) - 1;
      stall_next = 1'b1;
    end else begin
      stall_next = 1'b0;
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] thr;
    tick_result_t typed_res;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_SCRIPT; i++) begin
      typed_res.buzz = script[i].buzz;
      typed_res.act = script[i].act;
      typed_res.held = script[i].held;
      send_tick(mk_tick(script[i].time_ms, script[i].level, script[i].allowed),
                script[i].typed, typed_res);
    end
    now_ms = 32'd5000;
    run_random(240, 3000, HOOK_NONE);

    // all thresholds zero, zero-length beep
    set_config(16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_random(240, 3000, HOOK_NONE);

    // everything at its top value, long holds
    set_config(16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(240, 40000, HOOK_LONG_STALL);

    // ordered thresholds, small
    thr = 8'($urandom_range(0, 3));
    set_config(16'($urandom_range(1, 1500)), thr, thr + 8'($urandom_range(0, 3)),
               thr + 8'($urandom_range(4, 6)), thr + 8'($urandom_range(7, 10)));
    run_random(240, 3000, HOOK_PAUSE);

    // unordered, overlapping thresholds
    set_config(16'($urandom), 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
               8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
    run_random(240, 3000, HOOK_NONE);

    set_config(16'd1, 8'd1, 8'd2, 8'd3, 8'd4);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(240, 3000, HOOK_NONE);

    wait_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d ticks under %0d settings: %0d results, %0d beeps, %0d actions",
             ticks_sent, settings_used, results_seen, beeps_seen, actions_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
